[src/wsbs_pkg.sv]
// Shared types and constants of the WS2812 bit serializer.
package wsbs_pkg;

   localparam int unsigned TICK_WIDTH  = 12;
   localparam int unsigned LATCH_WIDTH = 17;
   localparam int unsigned BITS_WIDTH  = 4;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 17;

   localparam logic [TICK_WIDTH-1:0]  PERIOD_RESET = 12'd300;
   localparam logic [TICK_WIDTH-1:0]  ZERO_RESET   = 12'd96;
   localparam logic [TICK_WIDTH-1:0]  ONE_RESET    = 12'd192;
   localparam logic [LATCH_WIDTH-1:0] LATCH_RESET  = 17'd72000;

   localparam logic [BITS_WIDTH-1:0] BITS_PER_BYTE = 4'd8;

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH     = 4;
   localparam int unsigned QUEUE_PTR_WIDTH = 2;
   localparam int unsigned QUEUE_CNT_WIDTH = 3;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_BIT_PERIOD = 2'd0,
      REG_ZERO_HIGH  = 2'd1,
      REG_ONE_HIGH   = 2'd2,
      REG_LATCH      = 2'd3
   } wsbs_reg_type;

   // One tick as it travels from front to back
   typedef struct packed {
      logic       offer;
      logic [7:0] data;
      logic       last;
   } wsbs_item_type;

   // One tick of line output
   typedef struct packed {
      logic frame_done;
      logic busy;
      logic taken;
      logic line;
   } wsbs_result_type;

   // Configuration write beat
   typedef struct packed {
      logic                       valid;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  data;
   } wsbs_csr_type;

   // Handshake between queue and back
   typedef struct packed {
      logic          valid;
      wsbs_item_type item;
   } wsbs_pop_type;

endpackage

[src/wsbs_front.sv]
// Input stage: takes request beats and registers them as tick items.
module wsbs_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   input  logic                   req_tuser,
   output logic                   push_valid,
   output wsbs_pkg::wsbs_item_type push_item,
   input  logic                   push_ready
);
   import wsbs_pkg::*;

   logic          valid_ff, valid_in;
   wsbs_item_type item_ff, item_in;
   logic          take;

   // Accept a beat whenever the stage is empty or drains this cycle
   assign req_tready = !valid_ff || push_ready;
   assign take       = req_tvalid && req_tready;

   // Classify the beat: offered byte, payload and frame end
   always_comb begin
      item_in.offer = req_tuser;
      item_in.data  = req_tdata;
      item_in.last  = req_tlast;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

[src/wsbs_queue.sv]
// Short queue of tick items between the front and the back.
module wsbs_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  wsbs_pkg::wsbs_item_type push_item,
   output logic                    push_ready,
   output wsbs_pkg::wsbs_pop_type  pop,
   input  logic                    pop_ready
);
   import wsbs_pkg::*;

   wsbs_item_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0]   count_ff, count_in;
   logic                         do_push, do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign pop.valid  = (count_ff != '0);
   assign pop.item   = entry_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop.valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Occupancy never goes past the depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue occupancy above depth");

   // Pointer distance matches occupancy unless full or empty
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0 && count_ff != QUEUE_CNT_WIDTH'(QUEUE_DEPTH)) |->
         (QUEUE_PTR_WIDTH'(wr_ptr_ff - rd_ptr_ff) == count_ff[QUEUE_PTR_WIDTH-1:0]))
      else $error("queue pointers out of step with count");

   // Empty and full leave the pointers equal
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH)) |->
         (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers differ when empty or full");

endmodule

[src/wsbs_back.sv]
// Bit engine: serializes bytes into line ticks and holds the result register.
module wsbs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  wsbs_pkg::wsbs_csr_type csr,
   input  wsbs_pkg::wsbs_pop_type pop,
   output logic                   pop_ready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output wsbs_pkg::wsbs_result_type rsp_result
);
   import wsbs_pkg::*;

   // Configuration registers
   logic [TICK_WIDTH-1:0]  period_cfg_ff;
   logic [TICK_WIDTH-1:0]  zero_cfg_ff;
   logic [TICK_WIDTH-1:0]  one_cfg_ff;
   logic [LATCH_WIDTH-1:0] latch_cfg_ff;

   // Serializer state
   logic [7:0]             shift_ff, shift_in;
   logic [BITS_WIDTH-1:0]  bits_left_ff, bits_left_in;
   logic [TICK_WIDTH-1:0]  tick_ff, tick_in;
   logic [LATCH_WIDTH-1:0] latch_left_ff, latch_left_in;
   logic                   final_ff, final_in;

   // Output register
   logic            out_valid_ff, out_valid_in;
   wsbs_result_type out_ff, result;

   // Working values of the tick
   logic                  step;
   logic                  latch_phase, load;
   logic [7:0]            cur_shift;
   logic [BITS_WIDTH-1:0] cur_bits;
   logic [TICK_WIDTH-1:0] cur_tick, next_tick, period, high;
   logic                  cur_final;

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         period_cfg_ff <= PERIOD_RESET;
         zero_cfg_ff   <= ZERO_RESET;
         one_cfg_ff    <= ONE_RESET;
         latch_cfg_ff  <= LATCH_RESET;
      end else if (csr.valid) begin
         case (wsbs_reg_type'(csr.index))
            REG_BIT_PERIOD: period_cfg_ff <= csr.data[TICK_WIDTH-1:0];
            REG_ZERO_HIGH:  zero_cfg_ff   <= csr.data[TICK_WIDTH-1:0];
            REG_ONE_HIGH:   one_cfg_ff    <= csr.data[TICK_WIDTH-1:0];
            REG_LATCH:      latch_cfg_ff  <= csr.data[LATCH_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Run one tick whenever the result register can take it
   assign pop_ready = !out_valid_ff || rsp_tready;
   assign step      = pop.valid && pop_ready;

   always_comb begin
      shift_in      = shift_ff;
      bits_left_in  = bits_left_ff;
      tick_in       = tick_ff;
      latch_left_in = latch_left_ff;
      final_in      = final_ff;
      result        = '0;

      latch_phase = (bits_left_ff == '0) && final_ff;
      load        = !latch_phase && (bits_left_ff == '0) && pop.item.offer;

      cur_shift = load ? pop.item.data : shift_ff;
      cur_bits  = load ? BITS_PER_BYTE : bits_left_ff;
      cur_tick  = load ? '0 : tick_ff;
      cur_final = load ? pop.item.last : final_ff;

      // Treat a zero period as one tick and clip the high time to the period
      period    = (period_cfg_ff == '0) ? TICK_WIDTH'(1) : period_cfg_ff;
      high      = cur_shift[7] ? one_cfg_ff : zero_cfg_ff;
      if (high > period) begin
         high = period;
      end
      next_tick = cur_tick + 1'b1;

      if (latch_phase) begin
         // Hold the latch gap, then pulse frame done
         if (latch_left_ff != '0) begin
            latch_left_in = latch_left_ff - 1'b1;
            result.busy   = 1'b1;
         end else begin
            result.frame_done = 1'b1;
            final_in          = 1'b0;
         end
      end else begin
         result.taken = load;
         shift_in     = cur_shift;
         bits_left_in = cur_bits;
         tick_in      = cur_tick;
         final_in     = cur_final;
         if (cur_bits != '0) begin
            result.busy = 1'b1;
            result.line = (cur_tick < high);
            tick_in     = next_tick;
            // End of bit: drop the sent bit, start the latch after the last one
            if (next_tick >= period || next_tick == '0) begin
               tick_in      = '0;
               shift_in     = {cur_shift[6:0], 1'b0};
               bits_left_in = cur_bits - 1'b1;
               if (bits_left_in == '0 && cur_final) begin
                  latch_left_in = latch_cfg_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff      <= '0;
         bits_left_ff  <= '0;
         tick_ff       <= '0;
         latch_left_ff <= '0;
         final_ff      <= 1'b0;
      end else if (step) begin
         shift_ff      <= shift_in;
         bits_left_ff  <= bits_left_in;
         tick_ff       <= tick_in;
         latch_left_ff <= latch_left_in;
         final_ff      <= final_in;
      end
   end

   // Hold the result until the consumer takes it
   always_comb begin
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = out_ff;

   // A byte never holds more than eight bits
   assert property (@(posedge clock) disable iff (reset)
      bits_left_ff <= BITS_PER_BYTE)
      else $error("bit count above byte size");

   // A running latch count only exists in the latch phase
   assert property (@(posedge clock) disable iff (reset)
      (latch_left_ff != '0) |-> (final_ff && bits_left_ff == '0))
      else $error("latch count outside latch phase");

   // Frame done ends the gap: line low, not busy, no byte taken
   assert property (@(posedge clock) disable iff (reset)
      (step && result.frame_done) |=>
         (!out_ff.line && !out_ff.busy && !out_ff.taken && !final_ff))
      else $error("frame done with active line");

   // A taken byte always starts driving its first bit
   assert property (@(posedge clock) disable iff (reset)
      (step && result.taken) |=> (out_ff.busy && out_valid_ff))
      else $error("taken byte not sent");

endmodule

[src/ws2812_bit_serializer.sv]
// Top level of the WS2812 bit serializer: front stage, tick queue and bit engine.
//
// Every request beat is one clock tick of the LED line waveform and yields
// exactly one response beat describing that tick (line level, byte taken,
// busy, frame done). The block sustains one beat per cycle in both
// directions while neither side stalls; a beat passes from the input register
// through the four-entry queue to the result register, and the queue lets
// either side stall without losing ticks. Configuration writes are always
// accepted and should be issued while no beats are in flight.
module ws2812_bit_serializer (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request: tdata = data_byte[7:0]; tuser = byte_valid; tlast = last_byte
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,
   input  logic                                  req_tuser,
   input  logic                                  req_tlast,
   // Response: tdata = line_out, byte_taken, busy_res, frame_done, 4'b0
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,
   // Configuration write
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [wsbs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [wsbs_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import wsbs_pkg::*;

   logic            push_valid, push_ready, pop_ready;
   wsbs_item_type   push_item;
   wsbs_pop_type    pop;
   wsbs_csr_type    csr;
   wsbs_result_type rsp_result;

   assign csr_ready = 1'b1;
   assign csr.valid = csr_valid;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   wsbs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   wsbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_ready  (pop_ready)
   );

   wsbs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .pop        (pop),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   // Pack the response fields, first field lowest
   assign rsp_tdata = {4'b0000, rsp_result.frame_done, rsp_result.busy,
                       rsp_result.taken, rsp_result.line};

endmodule

[bench/ws2812_bit_serializer_tb.sv]
// Self-checking testbench of the WS2812 bit serializer: one beat per line tick.
`timescale 1ns / 1ps

module ws2812_bit_serializer_tb;
   import wsbs_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int PRESSURE_HOLD  = 300;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata  = '0;
   logic                       req_tuser  = 1'b0;
   logic                       req_tlast  = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [7:0]                 rsp_tdata;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data   = '0;

   // Configuration as the bench believes it is
   logic [TICK_WIDTH-1:0]  cfg_period;
   logic [TICK_WIDTH-1:0]  cfg_zero_high;
   logic [TICK_WIDTH-1:0]  cfg_one_high;
   logic [LATCH_WIDTH-1:0] cfg_latch;

   // Serializer state of the predictor
   logic [7:0]             ser_shift;
   logic [BITS_WIDTH-1:0]  ser_bits_left;
   logic [TICK_WIDTH-1:0]  ser_tick;
   logic [LATCH_WIDTH-1:0] ser_latch_left;
   logic                   ser_final;

   wsbs_result_type tick_expect_q[$];

   int mismatches     = 0;
   int idle_cycles    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int pressure_len   = 0;
   int hold_left      = 0;

   ws2812_bit_serializer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // data_byte[7:0]
      .req_tuser  (req_tuser),   // byte_valid
      .req_tlast  (req_tlast),   // last_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // line_out, byte_taken, busy_res, frame_done, 4'b0
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Advance the line waveform by one tick and return what the block should show
   function automatic wsbs_result_type line_tick(input logic offer, input logic [7:0] data,
                                                 input logic last);
      wsbs_result_type       r;
      logic [TICK_WIDTH-1:0] period;
      logic [TICK_WIDTH-1:0] high;
      r = '0;
      if (ser_bits_left == 0 && ser_final) begin
         // Latch gap: count down, then pulse frame done
         if (ser_latch_left != 0) begin
            ser_latch_left = ser_latch_left - 1'b1;
            r.busy = 1'b1;
         end else begin
            r.frame_done = 1'b1;
            ser_final = 1'b0;
         end
      end else begin
         if (ser_bits_left == 0 && offer) begin
            r.taken = 1'b1;
            ser_shift = data;
            ser_bits_left = BITS_PER_BYTE;
            ser_tick = '0;
            ser_final = last;
         end
         if (ser_bits_left != 0) begin
            period = (cfg_period == 0) ? TICK_WIDTH'(1) : cfg_period;
            high = ser_shift[7] ? cfg_one_high : cfg_zero_high;
            if (high > period) high = period;
            r.busy = 1'b1;
            r.line = (ser_tick < high);
            ser_tick = ser_tick + 1'b1;
            if (ser_tick >= period || ser_tick == 0) begin
               ser_tick = '0;
               ser_shift = ser_shift << 1;
               ser_bits_left = ser_bits_left - 1'b1;
               if (ser_bits_left == 0 && ser_final) ser_latch_left = cfg_latch;
            end
         end
      end
      return r;
   endfunction

   // Offer one tick beat, wait for it to be taken and queue its expected result
   task automatic send_tick(input logic offer, input logic [7:0] data, input logic last,
                            output wsbs_result_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= offer;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = line_tick(offer, data, last);
      tick_expect_q.push_back(want);
      @(negedge clock);
   endtask

   // Drain all beats in flight, then write one register
   task automatic csr_write(input wsbs_reg_type idx, input logic [CSR_DATA_WIDTH-1:0] value);
      req_tvalid <= 1'b0;
      while (tick_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_BIT_PERIOD: cfg_period    = value[TICK_WIDTH-1:0];
         REG_ZERO_HIGH:  cfg_zero_high = value[TICK_WIDTH-1:0];
         REG_ONE_HIGH:   cfg_one_high  = value[TICK_WIDTH-1:0];
         REG_LATCH:      cfg_latch     = value[LATCH_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Keep offering one byte tick after tick until the frame done pulse
   task automatic hold_until_done(input logic [7:0] data, input logic last);
      wsbs_result_type want;
      int              i;
      want = '0;
      for (i = 0; i < 64 && !want.frame_done; i++) send_tick(1'b1, data, last, want);
   endtask

   // Frames of a few bytes with random content, some gaps and some noise
   task automatic drive_frames(input int n_ticks);
      wsbs_result_type want;
      int              bytes_left;
      logic [7:0]      cur;
      int              i;
      bytes_left = 0;
      cur = '0;
      for (i = 0; i < n_ticks; i++) begin
         if (bytes_left == 0) begin
            bytes_left = $urandom_range(1, 4);
            cur = 8'($urandom);
         end
         if ($urandom_range(99) < 12) begin
            send_tick(1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)), want);
         end else if ($urandom_range(99) < 10) begin
            send_tick(1'b0, 8'($urandom), 1'($urandom_range(1)), want);
         end else begin
            send_tick(1'b1, cur, bytes_left == 1, want);
            if (want.taken) begin
               bytes_left--;
               cur = 8'($urandom);
            end
         end
      end
   endtask

   task automatic random_setting();
      csr_write(REG_BIT_PERIOD, CSR_DATA_WIDTH'($urandom_range(0, 6)));
      csr_write(REG_ZERO_HIGH, CSR_DATA_WIDTH'($urandom_range(0, 8)));
      csr_write(REG_ONE_HIGH, CSR_DATA_WIDTH'($urandom_range(0, 8)));
      csr_write(REG_LATCH, CSR_DATA_WIDTH'($urandom_range(0, 15)));
   endtask

   // Reset values, then period changes mid-bit (widest, then masked to one tick)
   task automatic test_defaults_midframe();
      wsbs_result_type want;
      send_tick(1'b0, 8'h00, 1'b0, want);
      send_tick(1'b1, 8'hFF, 1'b0, want);
      send_tick(1'b1, 8'h00, 1'b1, want);
      csr_write(REG_BIT_PERIOD, 17'd4095);
      send_tick(1'b1, 8'h00, 1'b1, want);
      csr_write(REG_BIT_PERIOD, 17'h10001);
      // Clip a one bit to the period, keep a zero bit low, no latch gap
      csr_write(REG_ZERO_HIGH, 17'd0);
      csr_write(REG_ONE_HIGH, 17'd4095);
      csr_write(REG_LATCH, 17'd0);
      hold_until_done(8'h00, 1'b1);
   endtask

   // Zero period acts as one tick; widest latch is written but replaced before use
   task automatic test_period_zero();
      wsbs_result_type want;
      csr_write(REG_BIT_PERIOD, 17'd0);
      csr_write(REG_LATCH, 17'h1FFFF);
      csr_write(REG_LATCH, 17'd3);
      csr_write(REG_ONE_HIGH, 17'd2);
      send_tick(1'b0, 8'hFF, 1'b1, want);
      hold_until_done(8'hC3, 1'b1);
   endtask

   task automatic test_traffic(input int send_pct, input int recv_pct, input int n_ticks);
      random_setting();
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      drive_frames(n_ticks);
   endtask

   // Stall the response side for a long stretch while ticks keep coming
   task automatic test_backpressure();
      random_setting();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      pressure_len   = PRESSURE_HOLD;
      drive_frames(60);
   endtask

   // Receiver: random stalls, plus the long hold-off on request
   always @(negedge clock) begin
      if (pressure_len != 0) begin
         hold_left = pressure_len;
         pressure_len = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compare each response beat with the oldest expected tick
   always @(posedge clock) begin
      wsbs_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tick_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %h", rsp_tdata);
         end else begin
            want = tick_expect_q.pop_front();
            if (rsp_tdata[0] !== want.line || rsp_tdata[1] !== want.taken ||
                rsp_tdata[2] !== want.busy || rsp_tdata[3] !== want.frame_done ||
                rsp_tdata[7:4] !== 4'b0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: line %b/%b taken %b/%b busy %b/%b done %b/%b pad %h",
                           want.line, rsp_tdata[0], want.taken, rsp_tdata[1],
                           want.busy, rsp_tdata[2], want.frame_done, rsp_tdata[3],
                           rsp_tdata[7:4]);
            end
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ws2812_bit_serializer_tb failed");
         $finish;
      end
   end

   initial begin
      cfg_period     = PERIOD_RESET;
      cfg_zero_high  = ZERO_RESET;
      cfg_one_high   = ONE_RESET;
      cfg_latch      = LATCH_RESET;
      ser_shift      = '0;
      ser_bits_left  = '0;
      ser_tick       = '0;
      ser_latch_left = '0;
      ser_final      = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_defaults_midframe();
      test_period_zero();
      test_traffic(0, 0, 200);
      test_traffic(75, 0, 200);
      test_traffic(0, 75, 200);
      test_traffic(8, 8, 200);
      test_backpressure();

      // Drain and let any stray beat show up
      req_tvalid <= 1'b0;
      while (tick_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && tick_expect_q.size() == 0)
         $display("ws2812_bit_serializer_tb passed");
      else
         $display("ws2812_bit_serializer_tb failed");
      $finish;
   end

endmodule

[sim.f]
src/wsbs_pkg.sv
src/wsbs_front.sv
src/wsbs_queue.sv
src/wsbs_back.sv
src/ws2812_bit_serializer.sv
bench/ws2812_bit_serializer_tb.sv
